@@ design/rgbla_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbla_pkg: shared constants and tables of the rgb led animation generator
// Per-phase color tables are built by constant functions at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbla_pkg;

    // phase ring
    localparam int PHASES    = 60;
    localparam int PHASE_W   = 6;

    // animation modes (code 3 behaves as pulse)
    localparam logic [1:0] MODE_WAVE    = 2'd0;
    localparam logic [1:0] MODE_RAINBOW = 2'd1;
    localparam logic [1:0] MODE_PULSE   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_RED   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_GREEN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_BLUE  = 8'd3;

    localparam int CH_W  = 8;
    localparam int VAL_W = 16;
    localparam int RGB_W = 3 * CH_W;

    // configuration seen by the scaling stage
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_color;

    // quarter-wave sine, signed q1.20, 6 degree steps
    function automatic longint quarter_sine(input int idx);
        longint q;
        case (idx)
            0:  q = 0;
            1:  q = 109606;
            2:  q = 218011;
            3:  q = 324028;
            4:  q = 426494;
            5:  q = 524288;
            6:  q = 616338;
            7:  q = 701634;
            8:  q = 779244;
            9:  q = 848316;
            10: q = 908093;
            11: q = 957922;
            12: q = 997255;
            13: q = 1025662;
            14: q = 1042832;
            default: q = 1048576;
        endcase
        return q;
    endfunction

    // full-wave sine from quarter-wave symmetry
    function automatic longint sine_of(input int p);
        longint s;
        if (p <= 15) begin
            s = quarter_sine(p);
        end else if (p <= 30) begin
            s = quarter_sine(30 - p);
        end else if (p <= 45) begin
            s = -quarter_sine(p - 30);
        end else begin
            s = -quarter_sine(60 - p);
        end
        return s;
    endfunction

    // brightness in q0.16, rounded half up, saturated
    function automatic longint value_calc(input longint base, input longint slope,
                                          input longint s);
        longint num;
        longint v;
        num = (base * 1048576 + slope * s) * 65536;
        v   = (num + 52428800) / 104857600;
        if (v > 65535) begin
            v = 65535;
        end
        return v;
    endfunction

    // hsv to rgb at full saturation, returned as {blue, green, red}
    function automatic logic [RGB_W-1:0] hue_rgb(input int p, input longint v);
        int     sector;
        int     tenths;
        longint m;
        longint c;
        longint x;
        logic [CH_W-1:0] cc;
        logic [CH_W-1:0] xx;
        logic [RGB_W-1:0] rgb;
        sector = p / 10;
        tenths = p % 10;
        m  = ((sector % 2) == 1) ? longint'(10 - tenths) : longint'(tenths);
        c  = (v * 255 + 32768) / 65536;
        x  = (v * m * 255 + 327680) / 655360;
        cc = CH_W'(c);
        xx = CH_W'(x);
        case (sector)
            0:       rgb = {8'd0, xx, cc};
            1:       rgb = {8'd0, cc, xx};
            2:       rgb = {xx, cc, 8'd0};
            3:       rgb = {cc, xx, 8'd0};
            4:       rgb = {cc, 8'd0, xx};
            default: rgb = {xx, 8'd0, cc};
        endcase
        return rgb;
    endfunction

    function automatic logic [PHASES-1:0][RGB_W-1:0] build_wave_rgb();
        logic [PHASES-1:0][RGB_W-1:0] t;
        for (int p = 0; p < PHASES; p++) begin
            t[p] = hue_rgb(p, value_calc(59, 41, sine_of(p)));
        end
        return t;
    endfunction

    function automatic logic [PHASES-1:0][RGB_W-1:0] build_rainbow_rgb();
        logic [PHASES-1:0][RGB_W-1:0] t;
        for (int p = 0; p < PHASES; p++) begin
            t[p] = hue_rgb(p, 65536);
        end
        return t;
    endfunction

    function automatic logic [PHASES-1:0][VAL_W-1:0] build_pulse_val();
        logic [PHASES-1:0][VAL_W-1:0] t;
        for (int p = 0; p < PHASES; p++) begin
            t[p] = VAL_W'(value_calc(56, 44, sine_of(p)));
        end
        return t;
    endfunction

    localparam logic [PHASES-1:0][RGB_W-1:0] WAVE_RGB    = build_wave_rgb();
    localparam logic [PHASES-1:0][RGB_W-1:0] RAINBOW_RGB = build_rainbow_rgb();
    localparam logic [PHASES-1:0][VAL_W-1:0] PULSE_VAL   = build_pulse_val();

endpackage

`default_nettype wire

@@ design/rgbla_scale.sv @@
// ----------------------------------------------------------------------------
// rgbla_scale: result stage of the animation generator
// Scales the pulse color by the brightness value or passes a hue color.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbla_scale
    import rgbla_pkg::*;
(
    input  wire logic              i_pulse,
    input  wire logic [RGB_W-1:0]  i_hue_rgb,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire t_color            i_color,
    output logic      [RGB_W-1:0]  o_rgb
);

    logic [CH_W+VAL_W:0] prod_r;
    logic [CH_W+VAL_W:0] prod_g;
    logic [CH_W+VAL_W:0] prod_b;

    // color times value, rounded half up to 8 bits
    always_comb begin
        prod_r = (CH_W+VAL_W+1)'(i_color.red)   * (CH_W+VAL_W+1)'(i_value)
                 + (CH_W+VAL_W+1)'(32768);
        prod_g = (CH_W+VAL_W+1)'(i_color.green) * (CH_W+VAL_W+1)'(i_value)
                 + (CH_W+VAL_W+1)'(32768);
        prod_b = (CH_W+VAL_W+1)'(i_color.blue)  * (CH_W+VAL_W+1)'(i_value)
                 + (CH_W+VAL_W+1)'(32768);
    end

    // pick pulse or hue color
    always_comb begin
        if (i_pulse) begin
            o_rgb = {prod_b[VAL_W +: CH_W], prod_g[VAL_W +: CH_W], prod_r[VAL_W +: CH_W]};
        end else begin
            o_rgb = i_hue_rgb;
        end
    end

endmodule

`default_nettype wire

@@ design/rgb_led_animation_generator_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_led_animation_generator_unit: frame color generator for an rgb led
// Wave, rainbow and pulse effects stepped by a 60-phase counter.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: each transfer carries frame_tick in tdata bit 0. A tick of 1
//   produces one color on the output stream and advances the phase; a tick of
//   0 is consumed with no result.
//   Output stream: tdata holds red, green, blue levels, red in the low byte.
//   Config channel: register index and data, always ready; index 0 mode,
//   1..3 pulse color; other indexes are dropped. Write only while idle.
// Timing
//   Two register stages: table lookup, then scaling into the output register.
//   One transfer per cycle is sustained while the receiver keeps up; the pulse
//   multipliers set the critical path.
// Reset and stall
//   Reset clears the phase, the configuration registers and both stage
//   valids. When the receiver stalls the output holds; the lookup stage
//   still takes one more tick, after which the input is held off.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_animation_generator_unit
    import rgbla_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream: [0] frame_tick, [7:1] zero
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [7:0]           i_s_axis_tdata,
    // output stream: [7:0] red_level, [15:8] green_level, [23:16] blue_level
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [RGB_W-1:0]     o_m_axis_tdata,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    logic [1:0]         r_mode;
    t_color             r_color;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;

    logic               r_s1_valid;
    logic               r_s1_pulse;
    logic [RGB_W-1:0]   r_s1_hue;
    logic [VAL_W-1:0]   r_s1_val;

    logic               r_out_valid;
    logic [RGB_W-1:0]   r_out_rgb;

    logic               out_free;
    logic               in_xfer;
    logic               tick;
    logic [RGB_W-1:0]   scaled_rgb;

    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign tick            = i_s_axis_tdata[0];
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_rgb;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_WAVE;
            r_color <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ANIM_MODE:   r_mode        <= i_cfg_data[1:0];
                REG_PULSE_RED:   r_color.red   <= i_cfg_data;
                REG_PULSE_GREEN: r_color.green <= i_cfg_data;
                REG_PULSE_BLUE:  r_color.blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase counter, wraps at the ring length
    always_comb begin
        if (r_phase == PHASE_W'(PHASES - 1)) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + PHASE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (in_xfer && tick) begin
            r_phase <= n_phase;
        end
    end

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= in_xfer && tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && tick) begin
            r_s1_pulse <= r_mode[1];
            r_s1_hue   <= (r_mode == MODE_RAINBOW) ? RAINBOW_RGB[r_phase] : WAVE_RGB[r_phase];
            r_s1_val   <= PULSE_VAL[r_phase];
        end
    end

    rgbla_scale u_scale (
        .i_pulse   (r_s1_pulse),
        .i_hue_rgb (r_s1_hue),
        .i_value   (r_s1_val),
        .i_color   (r_color),
        .o_rgb     (scaled_rgb)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_rgb <= scaled_rgb;
        end
    end

`ifndef SYNTH
    // phase never leaves the ring
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < PHASE_W'(PHASES))
        else $error("phase out of range");

    // a tick transfer advances the phase by one
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && tick) |=> (r_phase == $past(n_phase)))
        else $error("phase did not advance");

    // a tick transfer fills the lookup stage
    a_tick_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && tick) |=> r_s1_valid)
        else $error("tick lost in lookup stage");

    // a full lookup stage behind a stalled output keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_hue)))
        else $error("lookup stage dropped item under stall");
`endif

endmodule

`default_nettype wire
